@@ hw/rtl/base64_text_decoder_macros.svh @@
`ifndef BASE64_TEXT_DECODER_MACROS_SVH
`define BASE64_TEXT_DECODER_MACROS_SVH

// Same-cycle implication, checked on clk, off while arst_n is low
`define B64D_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base64 decoder check failed");

// Next-cycle implication, checked on clk, off while arst_n is low
`define B64D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base64 decoder check failed");

`endif

@@ hw/rtl/b64d_pkg.sv @@
`default_nettype none

package b64d_pkg;

	// Classified character as it travels from the front end to the back end
	typedef enum logic [1:0] {
		TOK_SYM,   // base64 symbol, value in sym_val
		TOK_PAD,   // '='
		TOK_BAD,   // character outside the alphabet
		TOK_END    // zero byte, end of message
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [5:0]  sym_val;
	} token_t;

	// Result kinds on the output channel
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_OK    = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/base64_text_decoder.sv @@
// Base64 text decoder.
// Input channel: one text byte per transaction (in_valid, in_ready, in_byte).
// A zero byte ends the message; whitespace and control bytes are dropped.
// Output channel: one result per transaction (out_valid, out_ready,
// result_kind, out_byte): a decoded data byte, message ok, or decode error.
// The front end classifies each byte in the cycle it is taken and pushes it
// into a small token queue; the back end pops one token a cycle while the
// output register is empty or being taken, updates the quartet state and
// loads any result into the output register. Throughput: one byte per
// cycle sustained while out_ready stays high, set by the single back-end
// step per token; the queue depth (QUEUE_DEPTH) absorbs short receiver
// stalls.
// When the receiver stalls, the output register holds, the queue fills and
// in_ready drops once it is full.
// After a decode error one error result is given and all bytes up to and
// including the terminating zero are discarded.
// Reset (arst_n low) empties the queue and the output register and returns
// the decoder to the start of a message.
`default_nettype none

module base64_text_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       out_byte
);
	import b64d_pkg::*;

	token_t push_tok;
	token_t head_tok;
	logic   push;
	logic   pop;
	logic   queue_full;
	logic   queue_empty;

	b64d_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_tok   (push_tok)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.head_tok (head_tok),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head_tok    (head_tok),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.out_byte    (out_byte)
	);

endmodule

`default_nettype wire

@@ hw/rtl/b64d_front.sv @@
`default_nettype none

module b64d_front (
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_byte,
	input  wire logic            queue_full,
	output logic                 push,
	output b64d_pkg::token_t     push_tok
);
	import b64d_pkg::*;

	logic skip;

	// Character classification
	always_comb begin
		skip             = 1'b0;
		push_tok.kind    = TOK_BAD;
		push_tok.sym_val = '0;
		priority if (in_byte == 8'd0) begin
			push_tok.kind = TOK_END;
		end else if (in_byte >= 8'h41 && in_byte <= 8'h5A) begin
			push_tok.kind    = TOK_SYM;
			push_tok.sym_val = 6'(in_byte - 8'h41);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h7A) begin
			push_tok.kind    = TOK_SYM;
			push_tok.sym_val = 6'(in_byte - 8'h61 + 8'd26);
		end else if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			push_tok.kind    = TOK_SYM;
			push_tok.sym_val = 6'(in_byte - 8'h30 + 8'd52);
		end else if (in_byte == 8'h2B) begin
			push_tok.kind    = TOK_SYM;
			push_tok.sym_val = 6'd62;
		end else if (in_byte == 8'h2F) begin
			push_tok.kind    = TOK_SYM;
			push_tok.sym_val = 6'd63;
		end else if (in_byte == 8'h3D) begin
			push_tok.kind = TOK_PAD;
		end else if (in_byte <= 8'd32) begin
			skip = 1'b1;
		end else if (in_byte >= 8'd127 && in_byte <= 8'd160) begin
			skip = 1'b1;
		end else begin
			push_tok.kind = TOK_BAD;
		end
	end

	// Whitespace and control bytes are taken and dropped here
	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full && !skip;

endmodule

`default_nettype wire

@@ hw/rtl/b64d_queue.sv @@
`default_nettype none
`include "base64_text_decoder_macros.svh"

module b64d_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire b64d_pkg::token_t    push_tok,
	input  wire logic                pop,
	output b64d_pkg::token_t         head_tok,
	output logic                     full,
	output logic                     empty
);
	import b64d_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	token_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_tok = slot_q[rd_q];

	// Storage slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_tok;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`B64D_ASSERT(queue_no_overflow, push, !full)
	`B64D_ASSERT(queue_no_underflow, pop, !empty)
	`B64D_ASSERT(queue_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

@@ hw/rtl/b64d_back.sv @@
`default_nettype none
`include "base64_text_decoder_macros.svh"

module b64d_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                queue_empty,
	input  wire b64d_pkg::token_t    head_tok,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               result_kind,
	output logic [7:0]               out_byte
);
	import b64d_pkg::*;

	// Quartet position
	localparam logic [2:0] PH_FIRST  = 3'd0;
	localparam logic [2:0] PH_SECOND = 3'd1;
	localparam logic [2:0] PH_THIRD  = 3'd2;
	localparam logic [2:0] PH_FOURTH = 3'd3;
	localparam logic [2:0] PH_PAD2   = 3'd4;

	logic [2:0] phase_q, phase_d;
	logic [5:0] sym_q, sym_d;      // previous symbol value
	logic       pad_q, pad_d;      // message closed by padding
	logic       err_q, err_d;      // error reported, discarding
	logic       out_valid_q;
	logic [1:0] result_kind_q;
	logic [7:0] out_byte_q;

	logic       advance;
	logic       emit;
	logic       bad_sym;
	logic       is_sym;
	logic       is_pad;
	logic [1:0] emit_kind;
	logic [7:0] emit_byte;

	assign advance = !queue_empty && (!out_valid_q || out_ready);
	assign pop     = advance;
	assign is_sym  = (head_tok.kind == TOK_SYM);
	assign is_pad  = (head_tok.kind == TOK_PAD);

	// Decode step for the token at the queue head
	always_comb begin
		phase_d   = phase_q;
		sym_d     = sym_q;
		pad_d     = pad_q;
		err_d     = err_q;
		emit      = 1'b0;
		bad_sym   = 1'b0;
		emit_kind = KIND_DATA;
		emit_byte = '0;
		if (head_tok.kind == TOK_END) begin
			phase_d = PH_FIRST;
			sym_d   = '0;
			pad_d   = 1'b0;
			err_d   = 1'b0;
			if (!err_q) begin
				emit      = 1'b1;
				emit_kind = (phase_q >= PH_SECOND && phase_q <= PH_PAD2) ?
					KIND_ERROR : KIND_OK;
			end
		end else if (!err_q) begin
			unique case (phase_q)
				PH_SECOND: begin
					if (is_sym) begin
						sym_d     = head_tok.sym_val;
						phase_d   = PH_THIRD;
						emit      = 1'b1;
						emit_byte = {sym_q, head_tok.sym_val[5:4]};
					end else begin
						bad_sym = 1'b1;
					end
				end
				PH_THIRD: begin
					if (is_pad) begin
						pad_d   = 1'b1;
						phase_d = PH_PAD2;
					end else if (is_sym) begin
						sym_d     = head_tok.sym_val;
						phase_d   = PH_FOURTH;
						emit      = 1'b1;
						emit_byte = {sym_q[3:0], head_tok.sym_val[5:2]};
					end else begin
						bad_sym = 1'b1;
					end
				end
				PH_FOURTH: begin
					if (is_pad) begin
						pad_d   = 1'b1;
						phase_d = PH_FIRST;
					end else if (is_sym) begin
						sym_d     = head_tok.sym_val;
						phase_d   = PH_FIRST;
						emit      = 1'b1;
						emit_byte = {sym_q[1:0], head_tok.sym_val};
					end else begin
						bad_sym = 1'b1;
					end
				end
				PH_PAD2: begin
					if (is_pad) begin
						phase_d = PH_FIRST;
					end else begin
						bad_sym = 1'b1;
					end
				end
				default: begin
					// unused codes behave as the first position
					if (is_sym && !pad_q) begin
						sym_d   = head_tok.sym_val;
						phase_d = PH_SECOND;
					end else begin
						bad_sym = 1'b1;
					end
				end
			endcase
			if (bad_sym) begin
				err_d     = 1'b1;
				emit      = 1'b1;
				emit_kind = KIND_ERROR;
			end
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			sym_q   <= '0;
			pad_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			sym_q   <= sym_d;
			pad_q   <= pad_d;
			err_q   <= err_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_kind_q <= emit_kind;
			out_byte_q    <= emit_byte;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign out_byte    = out_byte_q;

	`B64D_ASSERT_NEXT(end_clears_state, pop && head_tok.kind == TOK_END, phase_q == PH_FIRST && !err_q && !pad_q)
	`B64D_ASSERT(error_reported_on_entry, $rose(err_q), out_valid_q && result_kind_q == KIND_ERROR)
	`B64D_ASSERT(byte_zero_unless_data, out_valid_q && result_kind_q != KIND_DATA, out_byte_q == '0)

endmodule

`default_nettype wire
